/* src/gbs_pkg.sv */
// ----------------------------------------------------------------------------
// gbs_pkg: shared types and constants for greedy box suppression
// Controller states, cell control, overlap result and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package gbs_pkg;

  // fixed field widths
  localparam int unsigned THR_W       = 17;
  localparam int unsigned INDEX_W     = 16;
  localparam int unsigned EDGE_W      = 16;
  localparam int unsigned TOTAL_W     = 7;
  localparam int unsigned THR_SHIFT   = 16;

  // threshold after reset, 0.45 in Q1.16
  localparam logic [THR_W-1:0] THR_RESET = 17'd29491;

  // register stages in the overlap test unit
  localparam int unsigned PIPE_LAT = 4;

  // controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_DECIDE = 4'b1000
  } gbs_state_t;

  // per-cell control
  typedef struct packed {
    logic shift;  // take a box from the neighbour this cycle
    logic wrap;   // last live cell: take the head box instead
    logic load;   // store the current candidate
  } gbs_cell_ctrl_t;

  // overlap test outcome
  typedef struct packed {
    logic valid;
    logic hit;
  } gbs_hit_t;

endpackage

`default_nettype wire

/* src/gbs_cell.sv */
// ----------------------------------------------------------------------------
// gbs_cell: one slot of the kept-box ring
// Holds one kept box; rotates it towards the head or loads a new box.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_cell #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire                          clk,
  input  gbs_pkg::gbs_cell_ctrl_t      ctrl,
  input  wire  [4*COORD_BITS-1:0]      next_box,
  input  wire  [4*COORD_BITS-1:0]      head_box,
  input  wire  [4*COORD_BITS-1:0]      new_box,
  output logic [4*COORD_BITS-1:0]      box
);

  // slot contents: payload only, no reset
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      box <= new_box;
    end else if (ctrl.shift) begin
      box <= ctrl.wrap ? head_box : next_box;
    end
  end

endmodule

`default_nettype wire

/* src/gbs_overlap.sv */
// ----------------------------------------------------------------------------
// gbs_overlap: pipelined IoU threshold test
// Tests inter*65536 > threshold*union for one kept box per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_overlap #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  input  wire  [4*COORD_BITS-1:0]       kept_box,
  input  wire  [4*COORD_BITS-1:0]       cand_box,
  input  wire  [gbs_pkg::THR_W-1:0]     thr,
  output gbs_pkg::gbs_hit_t             result
);

  localparam int unsigned CW     = COORD_BITS;
  localparam int unsigned AREA_W = 2 * CW;
  localparam int unsigned UNI_W  = AREA_W + 1;
  localparam int unsigned PROD_W = UNI_W + gbs_pkg::THR_W;

  // saturating span
  function automatic logic [CW-1:0] span(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
    span = (hi > lo) ? (hi - lo) : '0;
  endfunction

  logic [CW-1:0] ka_x0, ka_y0, ka_x1, ka_y1;
  logic [CW-1:0] kc_x0, kc_y0, kc_x1, kc_y1;

  assign {ka_x0, ka_y0, ka_x1, ka_y1} = kept_box;
  assign {kc_x0, kc_y0, kc_x1, kc_y1} = cand_box;

  // stage 1: widths and heights
  logic          v1;
  logic [CW-1:0] wa, ha, wc, hc, iw, ih;

  always_ff @(posedge clk) begin
    wa <= span(ka_x0, ka_x1);
    ha <= span(ka_y0, ka_y1);
    wc <= span(kc_x0, kc_x1);
    hc <= span(kc_y0, kc_y1);
    iw <= span((ka_x0 > kc_x0) ? ka_x0 : kc_x0, (ka_x1 < kc_x1) ? ka_x1 : kc_x1);
    ih <= span((ka_y0 > kc_y0) ? ka_y0 : kc_y0, (ka_y1 < kc_y1) ? ka_y1 : kc_y1);
  end

  // stage 2: areas
  logic              v2;
  logic [AREA_W-1:0] area_a, area_c, inter2;

  always_ff @(posedge clk) begin
    area_a <= wa * ha;
    area_c <= wc * hc;
    inter2 <= iw * ih;
  end

  // stage 3: union; intersection never exceeds either area
  logic              v3;
  logic [UNI_W-1:0]  uni3;
  logic [AREA_W-1:0] inter3;

  always_ff @(posedge clk) begin
    uni3   <= UNI_W'(area_a) + UNI_W'(area_c) - UNI_W'(inter2);
    inter3 <= inter2;
  end

  // stage 4: scaled union and scaled intersection
  logic              v4;
  logic              uni_nz;
  logic [PROD_W-1:0] prod4;
  logic [PROD_W-1:0] inter_sh;

  always_ff @(posedge clk) begin
    prod4    <= PROD_W'(uni3) * PROD_W'(thr);
    inter_sh <= PROD_W'(inter3) << gbs_pkg::THR_SHIFT;
    uni_nz   <= (uni3 != '0);
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // a zero union never suppresses
  assign result.valid = v4;
  assign result.hit   = v4 && uni_nz && (inter_sh > prod4);

endmodule

`default_nettype wire

/* src/greedy_box_suppression_top.sv */
// Sequence: an accepted request rotates the k kept boxes past the overlap unit, k = boxes
// kept so far this frame after frame_start; the overlap pipeline then drains before the decision.
// With k zero the request goes straight to the decision. A new request is taken only while idle.
// The result register frees the input while a decided result waits.
// Reset: kept count cleared, threshold 29491 (0.45); the box ring is not cleared
// and needs no clearing pass, as only entries below the count are read.
// ----------------------------------------------------------------------------
// greedy_box_suppression_top: online greedy box suppression by IoU
// Ring of kept-box cells feeding a pipelined overlap test, with a small
// controller that scans, stores survivors and reports each decision.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_box_suppression_top #(
  parameter int unsigned MAX_KEPT   = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire                             clk,
  input  wire                             rst,
  // configuration
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [gbs_pkg::THR_W-1:0]       cfg_data,
  // box requests
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire                             frame_start,
  input  wire  [gbs_pkg::INDEX_W-1:0]     box_index,
  input  wire  [COORD_BITS-1:0]           left_edge,
  input  wire  [COORD_BITS-1:0]           top_edge,
  input  wire  [COORD_BITS-1:0]           right_edge,
  input  wire  [COORD_BITS-1:0]           bottom_edge,
  // decisions
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [gbs_pkg::INDEX_W-1:0]     result_index,
  output logic                            kept,
  output logic                            store_full,
  output logic [gbs_pkg::TOTAL_W-1:0]     kept_total
);

  localparam int unsigned CW      = COORD_BITS;
  localparam int unsigned BOX_W   = 4 * CW;
  localparam int unsigned CNT_W   = $clog2(MAX_KEPT + 1);
  localparam int unsigned DRAIN_W = $clog2(gbs_pkg::PIPE_LAT);
  localparam logic [CNT_W-1:0]   MAX_CNT   = CNT_W'(MAX_KEPT);
  localparam logic [DRAIN_W-1:0] DRAIN_TOP = DRAIN_W'(gbs_pkg::PIPE_LAT - 1);

  gbs_pkg::gbs_state_t state;
  logic [gbs_pkg::THR_W-1:0]   thr;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            count_m1;
  logic [CNT_W-1:0]            rot_left;
  logic [DRAIN_W-1:0]          drain_left;
  logic                        hit_acc;
  logic [BOX_W-1:0]            cand;
  logic [gbs_pkg::INDEX_W-1:0] cand_index;
  logic [CNT_W-1:0]            start_count;
  logic                        in_fire;
  logic                        decide_fire;
  logic                        store_load;
  logic                        scanning;
  gbs_pkg::gbs_hit_t           hit;
  logic [BOX_W-1:0]            cell_box [MAX_KEPT];

  // handshakes
  assign cfg_ready   = 1'b1;
  assign in_ready    = (state == gbs_pkg::ST_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign decide_fire = (state == gbs_pkg::ST_DECIDE) && (!out_valid || out_ready);
  assign store_load  = decide_fire && !hit_acc && (count < MAX_CNT);
  assign scanning    = (state == gbs_pkg::ST_SCAN);
  assign start_count = frame_start ? '0 : count;
  assign count_m1    = count - 1'b1;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= gbs_pkg::THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr <= cfg_data;
    end
  end

  // candidate register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cand       <= {left_edge, top_edge, right_edge, bottom_edge};
      cand_index <= box_index;
    end
  end

  // controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gbs_pkg::ST_IDLE;
      count      <= '0;
      rot_left   <= '0;
      drain_left <= '0;
      hit_acc    <= 1'b0;
    end else begin
      if (hit.valid && hit.hit) begin
        hit_acc <= 1'b1;
      end
      unique case (state)
        gbs_pkg::ST_IDLE: begin
          if (in_fire) begin
            count    <= start_count;
            rot_left <= start_count;
            hit_acc  <= 1'b0;
            state    <= (start_count == '0) ? gbs_pkg::ST_DECIDE : gbs_pkg::ST_SCAN;
          end
        end
        gbs_pkg::ST_SCAN: begin
          rot_left <= rot_left - 1'b1;
          if (rot_left == CNT_W'(1)) begin
            drain_left <= DRAIN_TOP;
            state      <= gbs_pkg::ST_DRAIN;
          end
        end
        gbs_pkg::ST_DRAIN: begin
          drain_left <= drain_left - 1'b1;
          if (drain_left == '0) begin
            state <= gbs_pkg::ST_DECIDE;
          end
        end
        gbs_pkg::ST_DECIDE: begin
          if (decide_fire) begin
            if (store_load) begin
              count <= count + 1'b1;
            end
            state <= gbs_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= gbs_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (decide_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (decide_fire) begin
      result_index <= cand_index;
      kept         <= store_load;
      store_full   <= !hit_acc && (count >= MAX_CNT);
      kept_total   <= gbs_pkg::TOTAL_W'(store_load ? count + 1'b1 : count);
    end
  end

  // ring of kept boxes; live cells rotate towards cell 0
  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    gbs_pkg::gbs_cell_ctrl_t ctrl;
    logic [BOX_W-1:0]        next_box;

    assign ctrl.shift = scanning && (CNT_W'(i) < count);
    assign ctrl.wrap  = (CNT_W'(i) == count_m1);
    assign ctrl.load  = store_load && (CNT_W'(i) == count);

    if (i == MAX_KEPT - 1) begin : g_last
      assign next_box = cell_box[0];
    end else begin : g_mid
      assign next_box = cell_box[i+1];
    end

    gbs_cell #(
      .COORD_BITS(COORD_BITS)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .next_box (next_box),
      .head_box (cell_box[0]),
      .new_box  (cand),
      .box      (cell_box[i])
    );
  end

  // overlap test on the head cell
  gbs_overlap #(
    .COORD_BITS(COORD_BITS)
  ) u_overlap (
    .clk      (clk),
    .rst      (rst),
    .in_valid (scanning),
    .kept_box (cell_box[0]),
    .cand_box (cand),
    .thr      (thr),
    .result   (hit)
  );

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_CNT)
    else $error("kept count beyond store size");

  a_result_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == gbs_pkg::ST_DECIDE))
    else $error("result raised outside decision");

  a_kept_or_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(kept && store_full))
    else $error("box both kept and flagged full");

  a_scan_count: assert property (@(posedge clk) disable iff (rst)
    (state == gbs_pkg::ST_SCAN) |-> (rot_left != '0))
    else $error("scan with no rotations left");

  a_hit_window: assert property (@(posedge clk) disable iff (rst)
    hit.valid |-> (state == gbs_pkg::ST_SCAN || state == gbs_pkg::ST_DRAIN))
    else $error("overlap result outside scan window");

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for greedy_box_suppression_top
// Sends frames of candidate boxes under several overlap thresholds and checks
// every decision against a scoreboard that runs greedy IoU suppression itself.
// ----------------------------------------------------------------------------

module testbench;

  localparam int unsigned THR_W     = gbs_pkg::THR_W;
  localparam int unsigned INDEX_W   = gbs_pkg::INDEX_W;
  localparam int unsigned EDGE_W    = gbs_pkg::EDGE_W;
  localparam int unsigned TOTAL_W   = gbs_pkg::TOTAL_W;
  localparam int unsigned THR_SHIFT = gbs_pkg::THR_SHIFT;
  localparam logic [THR_W-1:0] THR_RESET = gbs_pkg::THR_RESET;

  localparam int unsigned MAX_KEPT     = 64;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = MAX_KEPT + 16;
  localparam int unsigned PHASE_ITEMS  = 200;
  localparam int unsigned NUM_PHASES   = 6;
  localparam int unsigned GRID_CELLS   = 9;
  localparam int unsigned CELL_SPAN    = 65536 / GRID_CELLS;

  localparam logic [THR_W-1:0]  THR_ONE  = 17'h10000;
  localparam logic [THR_W-1:0]  THR_HALF = 17'h08000;
  localparam logic [THR_W-1:0]  THR_ZERO = 17'h00000;
  localparam logic [EDGE_W-1:0] EDGE_MAX = 16'hFFFF;

  // shapes drawn for random boxes
  typedef enum int {
    SH_SORTED, SH_RAW, SH_JITTER, SH_COPY, SH_FLAT, SH_SMALL, SH_WHOLE
  } shape_t;

  typedef struct packed {
    logic               frame_start;
    logic [INDEX_W-1:0] index;
    logic [EDGE_W-1:0]  left;
    logic [EDGE_W-1:0]  top;
    logic [EDGE_W-1:0]  right;
    logic [EDGE_W-1:0]  bottom;
  } box_req_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic               kept;
    logic               full;
    logic [TOTAL_W-1:0] total;
  } decision_t;

  // Scoreboard: own copy of the kept store, predicts one decision per request
  class nms_scoreboard;
    logic [THR_W-1:0] threshold;
    box_req_t         kept_store [MAX_KEPT];
    int unsigned      kept_count;
    decision_t        pending_decisions [$];
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      kept_seen;
    int unsigned      full_seen;
    int unsigned      full_suppressed;

    function new();
      threshold       = THR_RESET;
      kept_count      = 0;
      mismatches      = 0;
      checked         = 0;
      kept_seen       = 0;
      full_seen       = 0;
      full_suppressed = 0;
    endfunction

    // width of an edge pair, inverted pairs count as zero
    function logic [63:0] span(logic [EDGE_W-1:0] lo, logic [EDGE_W-1:0] hi);
      logic [63:0] a;
      logic [63:0] b;
      a = 64'(lo);
      b = 64'(hi);
      return (b > a) ? b - a : 64'd0;
    endfunction

    // inter * 65536 > threshold * union, zero union never suppresses
    function logic too_much_overlap(box_req_t k, box_req_t c);
      logic [63:0]       area_k;
      logic [63:0]       area_c;
      logic [63:0]       inter;
      logic [63:0]       uni;
      logic [63:0]       thr;
      logic [EDGE_W-1:0] il;
      logic [EDGE_W-1:0] it;
      logic [EDGE_W-1:0] ir;
      logic [EDGE_W-1:0] ib;
      area_k = span(k.left, k.right) * span(k.top, k.bottom);
      area_c = span(c.left, c.right) * span(c.top, c.bottom);
      il     = (k.left > c.left) ? k.left : c.left;
      it     = (k.top > c.top) ? k.top : c.top;
      ir     = (k.right < c.right) ? k.right : c.right;
      ib     = (k.bottom < c.bottom) ? k.bottom : c.bottom;
      inter  = span(il, ir) * span(it, ib);
      uni    = area_k + area_c - inter;
      thr    = 64'(threshold);
      if (uni == 64'd0) return 1'b0;
      return (inter << THR_SHIFT) > (uni * thr);
    endfunction

    // accepted request: decide it and queue the expected decision
    function void note_candidate(box_req_t req);
      decision_t d;
      logic      suppressed;
      int unsigned i;
      suppressed = 1'b0;
      if (req.frame_start) kept_count = 0;
      for (i = 0; i < kept_count; i++) begin
        if (!suppressed && too_much_overlap(kept_store[i], req)) suppressed = 1'b1;
      end
      d.index = req.index;
      d.kept  = 1'b0;
      d.full  = 1'b0;
      if (!suppressed) begin
        if (kept_count < MAX_KEPT) begin
          kept_store[kept_count] = req;
          kept_count++;
          d.kept = 1'b1;
          kept_seen++;
        end else begin
          d.full = 1'b1;
          full_seen++;
        end
      end else if (kept_count >= MAX_KEPT) begin
        full_suppressed++;
      end
      d.total = kept_count[TOTAL_W-1:0];
      pending_decisions = {pending_decisions, d};
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // decision accepted from the block: compare with the oldest expectation
    function void check_decision(decision_t got);
      decision_t want;
      if (pending_decisions.size() == 0) begin
        $display("%0t: decision for box %0d with nothing expected, expected none, actual %0d",
                 $time, got.index, got.index);
        mismatches++;
        return;
      end
      want = pending_decisions.pop_front();
      checked++;
      compare("result_index", 32'(want.index), 32'(got.index));
      compare("kept", 32'(want.kept), 32'(got.kept));
      compare("store_full", 32'(want.full), 32'(got.full));
      compare("kept_total", 32'(want.total), 32'(got.total));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [THR_W-1:0]    cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic                frame_start;
  logic [INDEX_W-1:0]  box_index;
  logic [EDGE_W-1:0]   left_edge;
  logic [EDGE_W-1:0]   top_edge;
  logic [EDGE_W-1:0]   right_edge;
  logic [EDGE_W-1:0]   bottom_edge;
  logic                out_valid;
  logic                out_ready;
  logic [INDEX_W-1:0]  result_index;
  logic                kept;
  logic                store_full;
  logic [TOTAL_W-1:0]  kept_total;

  nms_scoreboard board;
  bit            calm;
  box_req_t      frame_boxes [$];
  int unsigned   items_sent;
  int unsigned   frames_sent;
  int unsigned   thr_writes;

  always #2 clk = ~clk;

  greedy_box_suppression_top #(
    .MAX_KEPT   (MAX_KEPT),
    .COORD_BITS (EDGE_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .frame_start  (frame_start),
    .box_index    (box_index),
    .left_edge    (left_edge),
    .top_edge     (top_edge),
    .right_edge   (right_edge),
    .bottom_edge  (bottom_edge),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_index (result_index),
    .kept         (kept),
    .store_full   (store_full),
    .kept_total   (kept_total)
  );

  // one box request, after a random gap; returns at the accepting edge
  task automatic send_box(input box_req_t req);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    frame_start <= req.frame_start;
    box_index   <= req.index;
    left_edge   <= req.left;
    top_edge    <= req.top;
    right_edge  <= req.right;
    bottom_edge <= req.bottom;
    do @(posedge clk); while (in_ready !== 1'b1);
    board.note_candidate(req);
    items_sent++;
  endtask

  task automatic directed_box(input logic fs, input logic [INDEX_W-1:0] idx,
                              input logic [EDGE_W-1:0] l, input logic [EDGE_W-1:0] t,
                              input logic [EDGE_W-1:0] r, input logic [EDGE_W-1:0] b);
    box_req_t req;
    req.frame_start = fs;
    req.index       = idx;
    req.left        = l;
    req.top         = t;
    req.right       = r;
    req.bottom      = b;
    send_box(req);
  endtask

  // threshold write, only issued while the block is idle
  task automatic write_threshold(input logic [THR_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    board.threshold = value;
    thr_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop requests and wait for every outstanding decision
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending_decisions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // edge moved by a random offset in [lo_off, hi_off], clamped to the range
  function automatic logic [EDGE_W-1:0] shift_edge(logic [EDGE_W-1:0] e, int lo_off,
                                                   int hi_off);
    int          x;
    int unsigned r;
    r = $urandom_range(0, hi_off - lo_off);
    x = int'(e);
    x = x + r + lo_off;
    if (x < 0) x = 0;
    if (x > 65535) x = 65535;
    return EDGE_W'(x);
  endfunction

  // random box; jitter and copy shapes lean on boxes already sent this frame
  function automatic box_req_t make_box();
    box_req_t          b;
    box_req_t          src;
    logic [EDGE_W-1:0] u;
    logic [EDGE_W-1:0] v;
    logic [EDGE_W-1:0] w;
    logic [EDGE_W-1:0] z;
    int unsigned       pick;
    int                d;
    shape_t            shape;
    b    = '0;
    u    = EDGE_W'($urandom);
    v    = EDGE_W'($urandom);
    w    = EDGE_W'($urandom);
    z    = EDGE_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 22)      shape = SH_SORTED;
    else if (pick < 32) shape = SH_RAW;
    else if (pick < 58) shape = SH_JITTER;
    else if (pick < 66) shape = SH_COPY;
    else if (pick < 74) shape = SH_FLAT;
    else if (pick < 94) shape = SH_SMALL;
    else                shape = SH_WHOLE;
    if ((shape == SH_JITTER || shape == SH_COPY) && frame_boxes.size() == 0)
      shape = SH_SORTED;
    // sorted corners by default
    b.left   = (u < w) ? u : w;
    b.right  = (u < w) ? w : u;
    b.top    = (v < z) ? v : z;
    b.bottom = (v < z) ? z : v;
    case (shape)
      SH_RAW: begin
        b.left   = u;
        b.top    = v;
        b.right  = w;
        b.bottom = z;
      end
      SH_JITTER, SH_COPY: begin
        src = frame_boxes[$urandom_range(0, frame_boxes.size() - 1)];
        b   = src;
        if (shape == SH_JITTER) begin
          d        = int'($urandom_range(0, 3000));
          b.left   = shift_edge(src.left, -d, d);
          b.top    = shift_edge(src.top, -d, d);
          b.right  = shift_edge(src.right, -d, d);
          b.bottom = shift_edge(src.bottom, -d, d);
        end
      end
      SH_FLAT: begin
        if (u[0]) b.right = b.left;
        else b.bottom = b.top;
      end
      SH_SMALL: begin
        b.left   = u;
        b.top    = v;
        b.right  = shift_edge(u, 0, 3000);
        b.bottom = shift_edge(v, 0, 3000);
      end
      SH_WHOLE: begin
        b.left   = '0;
        b.top    = '0;
        b.right  = EDGE_MAX;
        b.bottom = EDGE_MAX;
      end
      default: ;
    endcase
    return b;
  endfunction

  // short frame of mixed shapes, with the odd stray frame start inside it
  task automatic short_frame();
    int unsigned n;
    int unsigned i;
    box_req_t    req;
    n = $urandom_range(1, 24);
    frame_boxes.delete();
    for (i = 0; i < n; i++) begin
      req             = make_box();
      req.frame_start = (i == 0) || ($urandom_range(0, 49) == 0);
      req.index       = INDEX_W'($urandom_range(0, 65535));
      frame_boxes     = {frame_boxes, req};
      send_box(req);
    end
    frames_sent++;
  endtask

  // long frame: disjoint grid boxes fill the store, then copies and new boxes
  task automatic long_frame();
    int unsigned cells [GRID_CELLS*GRID_CELLS];
    int unsigned i;
    int unsigned j;
    int unsigned t;
    int unsigned extra;
    int unsigned x;
    int unsigned y;
    box_req_t    req;
    for (i = 0; i < GRID_CELLS*GRID_CELLS; i++) cells[i] = i;
    for (i = GRID_CELLS*GRID_CELLS - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = cells[i];
      cells[i] = cells[j];
      cells[j] = t;
    end
    frame_boxes.delete();
    extra = $urandom_range(2, 12);
    for (i = 0; i < MAX_KEPT + extra; i++) begin
      if (i >= MAX_KEPT && $urandom_range(0, 1) == 0) begin
        req = frame_boxes[$urandom_range(0, MAX_KEPT - 1)];
      end else begin
        x          = (cells[i] % GRID_CELLS) * CELL_SPAN + $urandom_range(0, 2000);
        y          = (cells[i] / GRID_CELLS) * CELL_SPAN + $urandom_range(0, 2000);
        req.left   = EDGE_W'(x);
        req.top    = EDGE_W'(y);
        req.right  = EDGE_W'(x + $urandom_range(0, 5000));
        req.bottom = EDGE_W'(y + $urandom_range(0, 5000));
      end
      req.frame_start = (i == 0);
      req.index       = INDEX_W'($urandom_range(0, 65535));
      frame_boxes     = {frame_boxes, req};
      send_box(req);
    end
    frames_sent++;
  endtask

  // result side: random stalls, every accepted decision goes to the scoreboard
  initial begin : result_sink
    int unsigned gap;
    decision_t   got;
    out_ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 5);
      @(negedge clk);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.index = result_index;
      got.kept  = kept;
      got.full  = store_full;
      got.total = kept_total;
      board.check_decision(got);
    end
  end

  // watchdog: ends the run when no request moves for too long
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    wait (rst === 1'b0);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_ready === 1'b1) ||
          (out_valid === 1'b1 && out_ready === 1'b1) ||
          (cfg_valid === 1'b1 && cfg_ready === 1'b1)) idle = 0;
      else idle++;
    end
    $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // main sequence
  initial begin : stimulus
    logic [THR_W-1:0] phase_thr [NUM_PHASES];
    int unsigned      p;
    int unsigned      start;
    board       = new();
    calm        = 1'b0;
    items_sent  = 0;
    frames_sent = 0;
    thr_writes  = 0;
    in_valid    <= 1'b0;
    frame_start <= 1'b0;
    box_index   <= '0;
    left_edge   <= '0;
    top_edge    <= '0;
    right_edge  <= '0;
    bottom_edge <= '0;
    cfg_valid   <= 1'b0;
    cfg_data    <= '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset threshold: identical whole-frame pair is suppressed
    directed_box(1'b1, 16'h0000, 16'h0000, 16'h0000, EDGE_MAX, EDGE_MAX);
    directed_box(1'b0, 16'hFFFF, 16'h0000, 16'h0000, EDGE_MAX, EDGE_MAX);
    // point boxes: zero union, so the second one is kept too
    directed_box(1'b1, 16'h0001, 16'd100, 16'd100, 16'd100, 16'd100);
    directed_box(1'b0, 16'h0002, 16'd100, 16'd100, 16'd100, 16'd100);
    // inverted box has no area and overlaps nothing
    directed_box(1'b0, 16'h0003, 16'd500, 16'd100, 16'd100, 16'd600);
    // nested boxes either side of 0.45
    directed_box(1'b0, 16'h0004, 16'd0, 16'd0, 16'd1000, 16'd1000);
    directed_box(1'b0, 16'h0005, 16'd0, 16'd0, 16'd1000, 16'd1100);
    directed_box(1'b0, 16'h0006, 16'd0, 16'd0, 16'd1000, 16'd2000);
    directed_box(1'b0, 16'h0007, 16'd0, 16'd0, 16'd1000, 16'd3000);
    // corner extremes and alternating bit patterns
    directed_box(1'b1, 16'h5555, EDGE_MAX, EDGE_MAX, EDGE_MAX, EDGE_MAX);
    directed_box(1'b0, 16'hAAAA, 16'h5555, 16'h2AAA, 16'hAAAA, 16'hD555);
    directed_box(1'b0, 16'h8000, EDGE_MAX, EDGE_MAX, 16'h0000, 16'h0000);

    // IoU exactly at the threshold is not suppressed, just above it is
    drain();
    write_threshold(THR_HALF);
    directed_box(1'b1, 16'h0010, 16'd0, 16'd0, 16'd1000, 16'd1000);
    directed_box(1'b0, 16'h0011, 16'd0, 16'd0, 16'd1000, 16'd2000);
    directed_box(1'b0, 16'h0012, 16'd0, 16'd0, 16'd1000, 16'd1999);

    // threshold of one: identical boxes both survive
    drain();
    write_threshold(THR_ONE);
    directed_box(1'b1, 16'h0020, 16'd200, 16'd300, 16'd4000, 16'd5000);
    directed_box(1'b0, 16'h0021, 16'd200, 16'd300, 16'd4000, 16'd5000);

    // threshold of zero: a one-unit overlap suppresses
    drain();
    write_threshold(THR_ZERO);
    directed_box(1'b1, 16'h0030, 16'd1000, 16'd1000, 16'd2000, 16'd2000);
    directed_box(1'b0, 16'h0031, 16'd1999, 16'd1999, 16'd3000, 16'd3000);

    // random phases, one threshold each
    phase_thr[0] = THR_ONE;
    phase_thr[1] = THR_ZERO;
    phase_thr[2] = 17'd1;
    phase_thr[3] = 17'd65535;
    phase_thr[4] = THR_W'($urandom_range(0, 65536));
    phase_thr[5] = THR_W'($urandom_range(0, 65536));
    for (p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_threshold(phase_thr[p]);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        calm = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 5) == 0) long_frame();
        else short_frame();
      end
    end

    calm = 1'b0;
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d decisions in %0d frames under %0d threshold writes",
             board.checked, frames_sent, thr_writes);
    $display("Kept %0d, dropped on a full store %0d, suppressed with the store full %0d",
             board.kept_seen, board.full_seen, board.full_suppressed);
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
